FILE: hw/rtl/swrl_pkg.sv
// Shared types and constants of the sliding-window restart limiter.
package swrl_pkg;

	localparam int FUNC_W    = 2;
	localparam int TIME_W    = 32;
	localparam int LIMIT_W   = 5;
	localparam int LIVE_W    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_RECORD = 2'd0,
		FUNC_QUERY  = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXPIRY_WINDOW = 2'd0,
		REG_RESTART_LIMIT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PURGE,
		ST_APPLY
	} state_t;

endpackage

FILE: hw/rtl/swrl_if.sv
// Channel interfaces of the restart limiter: request, result and configuration.
interface swrl_req_if;
	import swrl_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [TIME_W-1:0] now_time;
	modport source (output valid, output func, output now_time, input ready);
	modport sink (input valid, input func, input now_time, output ready);
endinterface

interface swrl_rsp_if;
	import swrl_pkg::*;
	logic              valid;
	logic              ready;
	logic [LIVE_W-1:0] live_count;
	logic              limit_exceeded;
	logic              oldest_dropped;
	modport source (output valid, output live_count, output limit_exceeded,
		output oldest_dropped, input ready);
	modport sink (input valid, input live_count, input limit_exceeded,
		input oldest_dropped, output ready);
endinterface

interface swrl_cfg_if;
	import swrl_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/swrl_age_cmp.sv
// Shared age compare: a stamp is still live while its wrapped age is below the window.
module swrl_age_cmp (
	input  logic [swrl_pkg::TIME_W-1:0] now_time,
	input  logic [swrl_pkg::TIME_W-1:0] stamp,
	input  logic [swrl_pkg::TIME_W-1:0] window,
	output logic                        keep
);
	import swrl_pkg::*;

	logic [TIME_W-1:0] age;

	// The subtraction wraps modulo 2^32, so time running backwards gives a huge age.
	assign age  = now_time - stamp;
	assign keep = (age < window);

endmodule

FILE: hw/rtl/sliding_window_restart_limiter.sv
// Top level of the sliding-window restart limiter.
//
//   channel | modport | transfer carries                              | ready
//   --------+---------+-----------------------------------------------+----------------------
//   cfg     | sink    | index, data (register write)                  | always high
//   req     | sink    | func, now_time                                | high only when idle
//   rsp     | source  | live_count, limit_exceeded, oldest_dropped    | driven by downstream
//
// A record or query with a nonzero window walks the N stored stamps one per cycle
// through the single memory read port and the shared age compare; clear, unused
// codes and a zero window skip the walk. Request ready returns in the same cycle
// that the result becomes valid.
// Reset empties the ring at once (fill count and oldest pointer), the stamp memory
// itself is never cleared, and both registers return to zero.
// A stalled result holds the following item in its final step until the result
// transfer completes, so at most one more request is taken meanwhile.
module sliding_window_restart_limiter #(
	parameter int STORE_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	swrl_cfg_if.sink       cfg,
	swrl_req_if.sink       req,
	swrl_rsp_if.source     rsp
);
	import swrl_pkg::*;

	localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);
	localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(STORE_DEPTH);

	// Ring addressing: both operands are below the depth, so one compare and
	// subtract brings the sum back into range for any depth.
	function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] offs);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, offs};
		if (sum >= DEPTH_SUM) begin
			sum = sum - DEPTH_SUM;
		end
		return sum[IDX_W-1:0];
	endfunction

	// Control state.
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  ptr_q, ptr_d;
	logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0]  kept_q, kept_d;
	logic              pend_q, pend_d;
	logic              rsp_valid_q;

	// Configuration registers.
	logic [TIME_W-1:0]  window_q;
	logic [LIMIT_W-1:0] limit_q;

	// Captured request and result payload.
	logic [FUNC_W-1:0] func_q;
	logic [TIME_W-1:0] now_q;
	logic [LIVE_W-1:0] live_q;
	logic              exceeded_q;
	logic              dropped_q;

	// Stamp memory with one write port and one registered read port.
	logic [TIME_W-1:0] stamp_mem_q [STORE_DEPTH];
	logic [TIME_W-1:0] rdata_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [TIME_W-1:0] wr_data;

	logic              accept;
	logic              out_free;
	logic              keep;
	logic              load_rsp;
	logic              exceeded_d;
	logic              dropped_d;
	logic [CNT_W+LIVE_W-1:0] count_ext;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.live_count     = live_q;
	assign rsp.limit_exceeded = exceeded_q;
	assign rsp.oldest_dropped = dropped_q;

	// The age compare is a single unit shared by every purge step.
	swrl_age_cmp u_age_cmp (
		.now_time (now_q),
		.stamp    (rdata_q),
		.window   (window_q),
		.keep     (keep)
	);

	// Zero-extended count used for the limit compare and for the 6-bit report.
	assign count_ext = {{LIVE_W{1'b0}}, count_d};

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		ptr_d      = ptr_q;
		rd_idx_d   = rd_idx_q;
		kept_d     = kept_q;
		pend_d     = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = ring_slot(ptr_q, rd_idx_q[IDX_W-1:0]);
		wr_en      = 1'b0;
		wr_addr    = ring_slot(ptr_q, kept_q[IDX_W-1:0]);
		wr_data    = rdata_q;
		load_rsp   = 1'b0;
		dropped_d  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_idx_d = '0;
					kept_d   = '0;
					// Only record and query purge, and a zero window never expires.
					if ((req.func == FUNC_RECORD || req.func == FUNC_QUERY) &&
						window_q != '0) begin
						state_d = ST_PURGE;
					end else begin
						state_d = ST_APPLY;
					end
				end
			end
			ST_PURGE: begin
				// Issue one read per cycle, oldest first.
				if (rd_idx_q < count_q) begin
					rd_en    = 1'b1;
					rd_idx_d = rd_idx_q + 1'b1;
					pend_d   = 1'b1;
				end
				// The stamp read last cycle is judged now; a survivor moves down to
				// the next kept slot, which never lies ahead of the read position.
				if (pend_q && keep) begin
					wr_en  = 1'b1;
					kept_d = kept_q + 1'b1;
				end
				if (!(rd_idx_q < count_q) && !pend_q) begin
					count_d = kept_q;
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (out_free) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
					case (func_q)
						FUNC_RECORD: begin
							wr_en   = 1'b1;
							wr_data = now_q;
							if (count_q == DEPTH_CNT) begin
								// Still full after the purge: the newest overwrites the oldest.
								wr_addr   = ptr_q;
								ptr_d     = ring_slot(ptr_q, IDX_W'(1));
								dropped_d = 1'b1;
							end else begin
								wr_addr = ring_slot(ptr_q, count_q[IDX_W-1:0]);
								count_d = count_q + 1'b1;
							end
						end
						FUNC_CLEAR: begin
							count_d = '0;
							ptr_d   = '0;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		exceeded_d = (func_q == FUNC_RECORD) &&
			(count_ext > (CNT_W + LIVE_W)'(limit_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			rd_idx_q    <= '0;
			kept_q      <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			window_q    <= '0;
			limit_q     <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			ptr_q    <= ptr_d;
			rd_idx_q <= rd_idx_d;
			kept_q   <= kept_d;
			pend_q   <= pend_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_EXPIRY_WINDOW: window_q <= cfg.data[TIME_W-1:0];
					REG_RESTART_LIMIT: limit_q  <= cfg.data[LIMIT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Request capture and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			now_q  <= req.now_time;
		end
		if (load_rsp) begin
			live_q     <= count_ext[LIVE_W-1:0];
			exceeded_q <= exceeded_d;
			dropped_q  <= dropped_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= stamp_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_mem_q[wr_addr] <= wr_data;
		end
	end

endmodule

FILE: hw/rtl/swrl_checker.sv
// Port-level checker of the restart limiter and its bind to the top level.
module swrl_checker #(
	parameter int STORE_DEPTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [swrl_pkg::LIVE_W-1:0]   live_count,
	input logic                          limit_exceeded,
	input logic                          oldest_dropped
);
	import swrl_pkg::*;

	localparam logic [LIVE_W-1:0] DEPTH_LIVE = LIVE_W'(STORE_DEPTH);

	// A stalled result stays valid and keeps its live count until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(live_count))
		else $error("result changed while stalled");

	// One request at a time: the block is busy right after a request transfer.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// A new result appears only at the end of work, when no request was taken.
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared without work");

	// Overwriting the oldest entry happens only with the ring full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && oldest_dropped |-> live_count == DEPTH_LIVE)
		else $error("oldest dropped with ring not full");

	// Exceeding the limit needs at least one live entry.
	a_exceed_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && limit_exceeded |-> (STORE_DEPTH >= 64 || live_count != '0))
		else $error("limit exceeded with empty ring");

endmodule

bind sliding_window_restart_limiter swrl_checker #(
	.STORE_DEPTH (STORE_DEPTH)
) u_swrl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.live_count     (rsp.live_count),
	.limit_exceeded (rsp.limit_exceeded),
	.oldest_dropped (rsp.oldest_dropped)
);

FILE: test/swrl_result_checker.sv
// Result checker for the restart limiter: watches all three channels, predicts and compares.
module swrl_result_checker #(
	parameter int STORE_DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	swrl_cfg_if  cfg,
	swrl_req_if  req,
	swrl_rsp_if  rsp,
	output int   error_count,
	output int   verdicts_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import swrl_pkg::*;

	typedef struct packed {
		logic [LIVE_W-1:0] live_count;
		logic              limit_exceeded;
		logic              oldest_dropped;
	} verdict_t;

	// Shadow of the ring: stamps, index of the oldest entry and number of live entries.
	logic [TIME_W-1:0]  stamps [STORE_DEPTH];
	int                 head;
	int                 fill;
	logic [TIME_W-1:0]  window;
	logic [LIMIT_W-1:0] limit;
	verdict_t           due_q [$];

	// Removes every entry whose wrapped age reached the window; survivors keep their order.
	function automatic void drop_expired(input logic [TIME_W-1:0] now);
		int                kept;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] age;
		if (window == '0)
			return;
		kept = 0;
		for (int i = 0; i < fill; i++) begin
			stamp = stamps[(head + i) % STORE_DEPTH];
			age   = now - stamp;
			if (age < window) begin
				stamps[(head + kept) % STORE_DEPTH] = stamp;
				kept++;
			end
		end
		fill = kept;
	endfunction

	function automatic verdict_t predict_verdict(input logic [FUNC_W-1:0] code,
		input logic [TIME_W-1:0] now);
		verdict_t v;
		v = '0;
		case (code)
		FUNC_RECORD: begin
			drop_expired(now);
			if (fill >= STORE_DEPTH) begin
				stamps[head]     = now;
				head             = (head + 1) % STORE_DEPTH;
				v.oldest_dropped = 1'b1;
			end else begin
				stamps[(head + fill) % STORE_DEPTH] = now;
				fill++;
			end
			v.limit_exceeded = (fill > int'(limit));
		end
		FUNC_QUERY: drop_expired(now);
		FUNC_CLEAR: begin
			fill = 0;
			head = 0;
		end
		default: ;
		endcase
		v.live_count = LIVE_W'(fill);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			head        = 0;
			fill        = 0;
			window      = '0;
			limit       = '0;
			error_count = 0;
			due_q.delete();
			verdicts_due <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.live_count     = rsp.live_count;
				got.limit_exceeded = rsp.limit_exceeded;
				got.oldest_dropped = rsp.oldest_dropped;
				if (due_q.size() == 0) begin
					$error("unexpected result transfer: live_count %0d", got.live_count);
					error_count++;
				end else begin
					want = due_q.pop_front();
					if (got.live_count !== want.live_count) begin
						$error("live_count: expected %0d, actual %0d",
							want.live_count, got.live_count);
						error_count++;
					end
					if (got.limit_exceeded !== want.limit_exceeded) begin
						$error("limit_exceeded: expected %0b, actual %0b",
							want.limit_exceeded, got.limit_exceeded);
						error_count++;
					end
					if (got.oldest_dropped !== want.oldest_dropped) begin
						$error("oldest_dropped: expected %0b, actual %0b",
							want.oldest_dropped, got.oldest_dropped);
						error_count++;
					end
				end
			end
			if (req.valid && req.ready)
				due_q.push_back(predict_verdict(req.func, req.now_time));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_EXPIRY_WINDOW: window = cfg.data;
				REG_RESTART_LIMIT: limit = cfg.data[LIMIT_W-1:0];
				default: ;
				endcase
			end
			verdicts_due <= due_q.size();
		end
	end

endmodule

FILE: test/sliding_window_restart_limiter_tb.sv
// Testbench top for the restart limiter: stimulus, result sink, watchdog and verdict.
module sliding_window_restart_limiter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swrl_pkg::*;

	localparam int STORE_DEPTH    = 32;
	// Random traffic is split into PHASE_COUNT phases of PHASE_ITEMS items, each with its own settings.
	localparam int PHASE_COUNT    = 12;
	localparam int PHASE_ITEMS    = 150;
	// Settle time that covers a full purge, which walks every stamp once, and its overhead.
	localparam int SETTLE_CYCLES  = STORE_DEPTH + 8;
	// The long receiver stall that backs the block up into its request channel.
	localparam int HOLD_CYCLES    = 600;
	// Cycles with no transfer on any channel before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Function code that the block must treat as a no-op.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	int                error_count;
	int                verdicts_due;
	int                idle_cycles = 0;
	int                offered = 0;
	// Running time base used to build well-formed, mostly increasing timestamps.
	logic [TIME_W-1:0] wall;

	swrl_cfg_if cfg ();
	swrl_req_if req ();
	swrl_rsp_if rsp ();

	sliding_window_restart_limiter #(
		.STORE_DEPTH(STORE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.req   (req),
		.rsp   (rsp)
	);

	swrl_result_checker #(
		.STORE_DEPTH(STORE_DEPTH)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.req         (req),
		.rsp         (rsp),
		.error_count (error_count),
		.verdicts_due(verdicts_due)
	);

	always #2 clk = ~clk;

	// Offers one request. The gap before it is random, except in every third stretch of
	// 48 items, where requests go back to back. When there is no gap, valid simply stays
	// high from the previous transfer and only the payload changes.
	task automatic send_item(input logic [FUNC_W-1:0] code, input logic [TIME_W-1:0] stamp);
		int gap;
		gap = (((offered / 48) % 3) == 1) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.func     <= code;
		req.now_time <= stamp;
		do @(posedge clk); while (!req.ready);
		offered++;
	endtask

	// Stops offering and waits until every predicted result has come back. The checker
	// publishes its count through a register, so the loop waits on the clock before it reads it.
	// The extra settle time covers a purge that may still be winding down.
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (verdicts_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Writes both registers. The limit goes out with random upper data bits, which the
	// block must ignore since the register holds only five bits.
	task automatic configure(input logic [TIME_W-1:0] window, input logic [LIMIT_W-1:0] limit);
		logic [CFG_DAT_W-1:0] word;
		word              = $urandom();
		word[LIMIT_W-1:0] = limit;
		write_reg(REG_EXPIRY_WINDOW, window);
		write_reg(REG_RESTART_LIMIT, word);
		cfg.valid <= 1'b0;
	endtask

	// Moves the time base. Most steps go forward by up to max_step; some go a little
	// backwards, and a few jump anywhere, which makes whole groups of stamps look ancient.
	function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] max_step);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 88)
			wall += $urandom_range(0, max_step);
		else if (pick < 95)
			wall -= $urandom_range(0, max_step);
		else
			wall = $urandom();
		return wall;
	endfunction

	// Result side: random stalls, a calm stretch every third block of 40 results, and two
	// long holds while the sender keeps offering, so the block fills and stalls its input.
	initial begin : result_sink
		int stall;
		int taken;
		rsp.ready <= 1'b0;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken == 300 || taken == 1300)
				stall = HOLD_CYCLES;
			else if (((taken / 40) % 3) == 2)
				stall = 0;
			else
				stall = $urandom_range(0, 19);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			taken++;
		end
	end

	// The watchdog restarts on any transfer, so it only fires when the block hangs.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [TIME_W-1:0]  window;
		logic [LIMIT_W-1:0] limit;
		logic [TIME_W-1:0]  max_step;
		int                 clear_pct;
		int                 pick;
		logic [FUNC_W-1:0]  code;

		cfg.valid    <= 1'b0;
		cfg.index    <= REG_EXPIRY_WINDOW;
		cfg.data     <= '0;
		req.valid    <= 1'b0;
		req.func     <= FUNC_RECORD;
		req.now_time <= '0;
		wall = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, window of 100 and limit of 2. It starts with a query of the
		// empty ring, then pushes the count over the limit.
		configure(32'd100, 5'd2);
		send_item(FUNC_QUERY, 32'd0);
		send_item(FUNC_RECORD, 32'd0);
		send_item(FUNC_RECORD, 32'd5);
		send_item(FUNC_RECORD, 32'd10);
		// The unused code must neither purge nor change anything, even though the first
		// stamp is already old enough to expire here.
		send_item(FUNC_UNUSED, 32'd150);
		// An age past the window expires, one below it survives.
		send_item(FUNC_QUERY, 32'd104);
		// Time runs backwards past zero: the remaining stamps get huge ages and expire.
		send_item(FUNC_RECORD, 32'hFFFF_FFFF);
		send_item(FUNC_RECORD, 32'd0);
		send_item(FUNC_RECORD, 32'd99);
		send_item(FUNC_CLEAR, 32'h1234_5678);
		send_item(FUNC_QUERY, 32'hFFFF_FFFF);
		drain();

		// Largest window and a limit of zero: any record exceeds, and only an age of
		// all ones reaches the window.
		configure(32'hFFFF_FFFF, 5'd0);
		send_item(FUNC_RECORD, 32'd0);
		send_item(FUNC_QUERY, 32'hFFFF_FFFE);
		send_item(FUNC_QUERY, 32'hFFFF_FFFF);
		send_item(FUNC_UNUSED, 32'h8000_0000);
		drain();

		// A window of zero never expires anything; clear in the middle resets the ring.
		configure(32'd0, 5'd31);
		send_item(FUNC_RECORD, 32'h8000_0000);
		send_item(FUNC_RECORD, 32'h0000_0001);
		send_item(FUNC_QUERY, 32'h7FFF_FFFF);
		send_item(FUNC_CLEAR, 32'd0);
		send_item(FUNC_RECORD, 32'd7);
		send_item(FUNC_QUERY, 32'd7);
		drain();

		// Random part. Each phase picks register values, a time step that suits the
		// window, and how often the ring gets cleared. Phases without clears and with
		// slow expiry keep the ring full long enough to overwrite the oldest entry.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
			0: begin
				window = 32'd0; limit = 5'd31; max_step = 32'd1000; clear_pct = 0;
			end
			1: begin
				window = 32'hFFFF_FFFF; limit = 5'd0; max_step = 32'h0010_0000; clear_pct = 2;
			end
			2: begin
				window = 32'd1; limit = 5'd0; max_step = 32'd1; clear_pct = 3;
			end
			3: begin
				window = 32'd40; limit = 5'd5; max_step = 32'd4; clear_pct = 2;
			end
			4: begin
				window = 32'd200; limit = 5'd31; max_step = 32'd5; clear_pct = 0;
			end
			5: begin
				window    = $urandom_range(1, 1000);
				limit     = LIMIT_W'($urandom());
				max_step  = window / 16 + 1;
				clear_pct = 3;
			end
			6: begin
				window = 32'h8000_0000; limit = 5'd16; max_step = 32'h0400_0000; clear_pct = 1;
			end
			7: begin
				window = 32'd0; limit = 5'd0; max_step = 32'd3; clear_pct = 10;
			end
			8: begin
				window    = $urandom();
				limit     = LIMIT_W'($urandom());
				max_step  = 32'h0100_0000;
				clear_pct = 2;
			end
			9: begin
				window = 32'd30; limit = 5'd31; max_step = 32'd1; clear_pct = 0;
			end
			10: begin
				window = 32'd1000; limit = 5'd10; max_step = 32'd50; clear_pct = 5;
			end
			default: begin
				window = 32'hFFFF_FFFF; limit = 5'd31; max_step = 32'h7FFF_FFFF; clear_pct = 0;
			end
			endcase
			configure(window, limit);
			// Some phases start just below the wrap point so stamps straddle zero.
			wall = ($urandom_range(0, 1) == 0) ? $urandom() : (32'hFFFF_FFFF - $urandom_range(0, 500));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					code = FUNC_RECORD;
				else if (pick < 90 - clear_pct)
					code = FUNC_QUERY;
				else if (pick < 90)
					code = FUNC_CLEAR;
				else if (pick < 95)
					code = FUNC_UNUSED;
				else
					code = FUNC_QUERY;
				send_item(code, next_stamp(max_step));
			end
			drain();
		end

		// Everything has been answered once drain returns; a hang is the watchdog's job.
		if (error_count == 0 && verdicts_due == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/swrl_pkg.sv
hw/rtl/swrl_if.sv
hw/rtl/swrl_age_cmp.sv
hw/rtl/sliding_window_restart_limiter.sv
hw/rtl/swrl_checker.sv
test/swrl_result_checker.sv
test/sliding_window_restart_limiter_tb.sv
